>>> rtl/core/qfa_pkg.sv
// Shared types, codes and constants for the queue family assigner.
package qfa_pkg;

  localparam int FLAG_BITS     = 8;
  localparam int SCORE_W       = 15;
  localparam int POS_W         = SCORE_W - 1;
  localparam int PREF_WEIGHT   = 1000;
  localparam int EXCESS_WEIGHT = 100;
  localparam int PRESENT_BONUS = 1000;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SOLVE  = 2'd2;

  localparam logic [1:0] PM_IGNORE   = 2'd0;
  localparam logic [1:0] PM_OPTIONAL = 2'd1;
  localparam logic [1:0] PM_REQUIRED = 2'd2;

  localparam logic [1:0] AV_REQUIRED = 2'd0;
  localparam logic [1:0] AV_OPTIONAL = 2'd1;
  localparam logic [1:0] AV_NEVER    = 2'd2;

  typedef logic [FLAG_BITS-1:0] flags_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] family_flags;
    logic [7:0] family_slots;
    logic       family_present;
    logic [7:0] require_mask;
    logic [7:0] prefer_mask;
    logic [7:0] exclude_mask;
    logic [1:0] present_mode;
    logic [1:0] availability;
  } in_word_t;

  typedef struct packed {
    logic [3:0] request_number;
    logic       assigned;
    logic [3:0] family_number;
    logic [7:0] slot_number;
    logic       failed;
    logic       last;
  } out_word_t;

  typedef struct packed {
    flags_t     flags;
    logic [7:0] slots;
    logic       present;
  } fam_entry_t;

  typedef struct packed {
    flags_t     require;
    flags_t     prefer;
    flags_t     exclude;
    logic [1:0] present;
    logic [1:0] avail;
  } req_entry_t;

endpackage

>>> rtl/core/qfa_score_unit.sv
// Match test and score of one family against one request.
module qfa_score_unit (
  input  qfa_pkg::fam_entry_t fam,
  input  logic [7:0]          used,
  input  qfa_pkg::req_entry_t req,
  output logic                match,
  output qfa_pkg::score_t     score
);
  import qfa_pkg::*;

  flags_t     pref;
  flags_t     relevant;
  flags_t     hit_bits;
  flags_t     excess_bits;
  logic [5:0] hits;
  logic [5:0] excess;
  logic [7:0] room;
  logic       bonus;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] neg;

  always_comb begin
    pref        = req.prefer & ~req.require & ~req.exclude;
    relevant    = req.require | pref;
    hit_bits    = fam.flags & pref;
    excess_bits = fam.flags & ~relevant;
    hits        = '0;
    excess      = '0;
    for (int b = 0; b < FLAG_BITS; b++) begin
      hits   = hits + 6'(hit_bits[b]);
      excess = excess + 6'(excess_bits[b]);
    end
    room  = fam.slots - used;
    bonus = (req.present == PM_OPTIONAL) && fam.present;
    match = (used < fam.slots)
         && ((fam.flags & req.require) == req.require)
         && ((fam.flags & req.exclude) == '0)
         && !((req.present == PM_REQUIRED) && !fam.present);
    pos   = POS_W'(hits) * POS_W'(PREF_WEIGHT) + POS_W'(room)
          + (bonus ? POS_W'(PRESENT_BONUS) : '0);
    neg   = POS_W'(excess) * POS_W'(EXCESS_WEIGHT);
    score = $signed({1'b0, pos}) - $signed({1'b0, neg});
  end

endmodule

>>> rtl/core/qfa_solver.sv
// Family and request tables with the sequencer that runs the assignment passes.
module qfa_solver #(
  parameter int MAX_FAMILIES = 16,
  parameter int MAX_REQUESTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  qfa_pkg::in_word_t  item,
  output logic               res_valid,
  input  logic               res_ready,
  output qfa_pkg::out_word_t res
);
  import qfa_pkg::*;

  localparam int FIW = (MAX_FAMILIES > 1) ? $clog2(MAX_FAMILIES) : 1;
  localparam int RIW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int FCW = $clog2(MAX_FAMILIES + 1);
  localparam int RCW = $clog2(MAX_REQUESTS + 1);

  typedef struct packed {
    logic           found;
    logic [FIW-1:0] fam;
    logic [7:0]     slot;
  } asg_entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_REQ_FETCH, S_REQ_CHECK, S_FAM_FETCH, S_FAM_EVAL,
    S_COMMIT, S_EMIT_FETCH, S_EMIT_SEND, S_FAIL
  } state_t;

  state_t         state;
  logic [FCW-1:0] family_total;
  logic [RCW-1:0] request_total;
  logic [RCW-1:0] req_idx;
  logic [FCW-1:0] fam_idx;
  logic           pass;
  logic           found;
  score_t         lead_score;
  logic [FIW-1:0] best_idx;
  logic [7:0]     best_slot;

  fam_entry_t fam_mem   [MAX_FAMILIES];
  logic [7:0] slots_mem [MAX_FAMILIES];
  req_entry_t req_mem   [MAX_REQUESTS];
  asg_entry_t asg_mem   [MAX_REQUESTS];

  fam_entry_t fam_q;
  logic [7:0] used_q;
  req_entry_t req_q;
  asg_entry_t asg_q;

  logic       fire;
  logic       load_go;
  logic       append_go;
  logic       req_last;
  logic       fam_last;
  logic       match;
  score_t     score;
  logic [1:0] want;
  fam_entry_t fam_in;
  req_entry_t req_in;
  logic       slot_we;
  logic [FIW-1:0] slot_addr;
  logic [7:0] slot_data;
  logic       assigned;

  qfa_score_unit u_score (
    .fam   (fam_q),
    .used  (used_q),
    .req   (req_q),
    .match (match),
    .score (score)
  );

  always_comb begin
    fire       = item_valid && item_ready;
    load_go    = fire && (item.operation == OP_LOAD)
              && (family_total < FCW'(MAX_FAMILIES));
    append_go  = fire && (item.operation == OP_APPEND)
              && (request_total < RCW'(MAX_REQUESTS));
    req_last   = (req_idx + RCW'(1)) == request_total;
    fam_last   = (fam_idx + FCW'(1)) == family_total;
    want       = pass ? AV_OPTIONAL : AV_REQUIRED;
    fam_in.flags   = item.family_flags;
    fam_in.slots   = item.family_slots;
    fam_in.present = item.family_present;
    req_in.require = item.require_mask;
    req_in.prefer  = item.prefer_mask;
    req_in.exclude = item.exclude_mask;
    req_in.present = (item.present_mode == 2'd3) ? PM_IGNORE : item.present_mode;
    req_in.avail   = (item.availability == 2'd3) ? AV_NEVER : item.availability;
    slot_we    = load_go || ((state == S_COMMIT) && found);
    slot_addr  = load_go ? family_total[FIW-1:0] : best_idx;
    slot_data  = load_go ? 8'd0 : best_slot + 8'd1;
    assigned   = asg_q.found && (req_q.avail != AV_NEVER);
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      fam_mem[family_total[FIW-1:0]] <= fam_in;
    end
    if (slot_we) begin
      slots_mem[slot_addr] <= slot_data;
    end
    if (append_go) begin
      req_mem[request_total[RIW-1:0]] <= req_in;
    end
    if (state == S_COMMIT) begin
      asg_mem[req_idx[RIW-1:0]] <= '{found: found, fam: best_idx, slot: best_slot};
    end
    fam_q  <= fam_mem[fam_idx[FIW-1:0]];
    used_q <= slots_mem[fam_idx[FIW-1:0]];
    req_q  <= req_mem[req_idx[RIW-1:0]];
    asg_q  <= asg_mem[req_idx[RIW-1:0]];
  end

  always_comb begin
    item_ready = (state == S_IDLE);
    res_valid  = (state == S_EMIT_SEND) || (state == S_FAIL);
    res.request_number = 4'(req_idx);
    res.assigned       = 1'b0;
    res.family_number  = 4'd0;
    res.slot_number    = 8'd0;
    res.failed         = 1'b0;
    res.last           = 1'b0;
    case (state)
      S_EMIT_SEND: begin
        res.assigned      = assigned;
        res.family_number = assigned ? 4'(asg_q.fam) : 4'd0;
        res.slot_number   = assigned ? asg_q.slot : 8'd0;
        res.last          = req_last;
      end
      S_FAIL: begin
        res.failed = 1'b1;
        res.last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      family_total  <= '0;
      request_total <= '0;
      req_idx       <= '0;
      fam_idx       <= '0;
      pass          <= 1'b0;
      found         <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (load_go) begin
            family_total <= family_total + FCW'(1);
          end
          if (append_go) begin
            request_total <= request_total + RCW'(1);
          end
          if (fire && (item.operation == OP_SOLVE)) begin
            req_idx <= '0;
            pass    <= 1'b0;
            if (request_total == '0) begin
              family_total <= '0;
            end else begin
              state <= S_REQ_FETCH;
            end
          end
        end
        S_REQ_FETCH: begin
          state <= S_REQ_CHECK;
        end
        S_REQ_CHECK: begin
          if (req_q.avail == want) begin
            found   <= 1'b0;
            fam_idx <= '0;
            state   <= (family_total == '0) ? S_COMMIT : S_FAM_FETCH;
          end else if (!req_last) begin
            req_idx <= req_idx + RCW'(1);
            state   <= S_REQ_FETCH;
          end else if (!pass) begin
            pass    <= 1'b1;
            req_idx <= '0;
            state   <= S_REQ_FETCH;
          end else begin
            req_idx <= '0;
            state   <= S_EMIT_FETCH;
          end
        end
        S_FAM_FETCH: begin
          state <= S_FAM_EVAL;
        end
        S_FAM_EVAL: begin
          if (match && (!found || (score > lead_score))) begin
            found      <= 1'b1;
            lead_score <= score;
            best_idx   <= fam_idx[FIW-1:0];
            best_slot  <= used_q;
          end
          fam_idx <= fam_idx + FCW'(1);
          state   <= fam_last ? S_COMMIT : S_FAM_FETCH;
        end
        S_COMMIT: begin
          if (!found && !pass) begin
            state <= S_FAIL;
          end else if (!req_last) begin
            req_idx <= req_idx + RCW'(1);
            state   <= S_REQ_FETCH;
          end else if (!pass) begin
            pass    <= 1'b1;
            req_idx <= '0;
            state   <= S_REQ_FETCH;
          end else begin
            req_idx <= '0;
            state   <= S_EMIT_FETCH;
          end
        end
        S_EMIT_FETCH: begin
          state <= S_EMIT_SEND;
        end
        S_EMIT_SEND: begin
          if (res_ready) begin
            if (req_last) begin
              family_total  <= '0;
              request_total <= '0;
              state         <= S_IDLE;
            end else begin
              req_idx <= req_idx + RCW'(1);
              state   <= S_EMIT_FETCH;
            end
          end
        end
        S_FAIL: begin
          if (res_ready) begin
            family_total  <= '0;
            request_total <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/queue_family_assigner.sv
// Top level of the queue family assigner: sequencer plus output register.
//
// Family loads and request appends are taken while the block is idle. A solve
// runs through the request list twice (required requests, then optional ones)
// on a single score/compare unit fed from registered table reads: a request
// outside the current pass is fetched and checked, a served request is also
// scored against each loaded family in turn and then committed, and each
// result word is fetched from the assignment table and then sent. A failed
// required request ends the solve with one error word. The block takes no new
// word while a solve runs; result words wait in an output register.
module queue_family_assigner #(
  parameter int MAX_FAMILIES = 16,
  parameter int MAX_REQUESTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  qfa_pkg::in_word_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output qfa_pkg::out_word_t result
);
  import qfa_pkg::*;

  logic      res_valid;
  logic      res_ready;
  out_word_t res;

  qfa_solver #(
    .MAX_FAMILIES (MAX_FAMILIES),
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_solver (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      result <= res;
    end
  end

endmodule

>>> tb/sv/tb_queue_family_assigner.sv
// Self-checking testbench for the queue family assigner: directed table, then random solves.
module tb_queue_family_assigner;
  import qfa_pkg::*;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam logic [1:0] PM_RESERVED = 2'd3;
  localparam logic [1:0] AV_RESERVED = 2'd3;
  localparam int TABLE_DEPTH  = 16;
  localparam int TOTAL_WORDS  = 213;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 600000;

  logic      clk = 1'b0;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_word_t  item;
  logic      result_valid;
  logic      result_ready;
  out_word_t result;

  queue_family_assigner u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fam_entry_t fam_tab [TABLE_DEPTH];
  req_entry_t req_tab [TABLE_DEPTH];
  logic [7:0] used_slots [TABLE_DEPTH];
  out_word_t  placement [TABLE_DEPTH];
  int         fam_count;
  int         req_count;

  out_word_t  solve_locs [$];
  out_word_t  awaited_locations [$];
  out_word_t  head_loc;

  in_word_t   plan_word [$];
  bit         plan_typed [$];
  out_word_t  plan_loc [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int words_sent;
  int solves_seen;
  int aborts_seen;
  int locations_checked;
  int mismatch_count;
  int cycle_count;

  function automatic bit place_request(input int idx);
    req_entry_t r;
    fam_entry_t e;
    flags_t     pref;
    flags_t     relevant;
    int         score;
    int         lead_score;
    int         best;
    bit         found;
    r = req_tab[idx];
    pref = r.prefer & ~r.require & ~r.exclude;
    relevant = r.require | pref;
    found = 1'b0;
    best = 0;
    lead_score = 0;
    for (int f = 0; f < fam_count; f++) begin
      e = fam_tab[f];
      if (used_slots[f] >= e.slots) continue;
      if ((e.flags & r.require) != r.require) continue;
      if ((e.flags & r.exclude) != '0) continue;
      if (r.present == PM_REQUIRED && !e.present) continue;
      score = PREF_WEIGHT * $countones(e.flags & pref)
            - EXCESS_WEIGHT * $countones(e.flags & ~relevant)
            + int'(e.slots) - int'(used_slots[f]);
      if (r.present == PM_OPTIONAL && e.present) score += PRESENT_BONUS;
      if (!found || score > lead_score) begin
        found = 1'b1;
        lead_score = score;
        best = f;
      end
    end
    if (found) begin
      placement[idx].assigned = 1'b1;
      placement[idx].family_number = best[3:0];
      placement[idx].slot_number = used_slots[best];
      used_slots[best] = used_slots[best] + 8'd1;
    end
    return found;
  endfunction

  function automatic void predict_word(input in_word_t w);
    logic [1:0] pm;
    logic [1:0] av;
    bit         aborted;
    int         abort_idx;
    solve_locs.delete();
    case (w.operation)
      OP_LOAD: begin
        if (fam_count < TABLE_DEPTH) begin
          fam_tab[fam_count] = {w.family_flags, w.family_slots, w.family_present};
          fam_count++;
        end
      end
      OP_APPEND: begin
        if (req_count < TABLE_DEPTH) begin
          pm = (w.present_mode == PM_RESERVED) ? PM_IGNORE : w.present_mode;
          av = (w.availability == AV_RESERVED) ? AV_NEVER : w.availability;
          req_tab[req_count] = {w.require_mask, w.prefer_mask, w.exclude_mask, pm, av};
          req_count++;
        end
      end
      OP_SOLVE: begin
        solves_seen++;
        aborted = 1'b0;
        abort_idx = 0;
        for (int f = 0; f < TABLE_DEPTH; f++) used_slots[f] = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          placement[i] = '0;
          placement[i].request_number = i[3:0];
        end
        for (int i = 0; i < req_count && !aborted; i++) begin
          if (req_tab[i].avail == AV_REQUIRED && !place_request(i)) begin
            aborted = 1'b1;
            abort_idx = i;
          end
        end
        if (aborted) begin
          aborts_seen++;
          solve_locs.push_back({abort_idx[3:0], 1'b0, 4'd0, 8'd0, 1'b1, 1'b1});
        end else begin
          for (int i = 0; i < req_count; i++)
            if (req_tab[i].avail == AV_OPTIONAL) void'(place_request(i));
          for (int i = 0; i < req_count; i++) begin
            placement[i].last = (i == req_count - 1);
            solve_locs.push_back(placement[i]);
          end
        end
        fam_count = 0;
        req_count = 0;
        for (int f = 0; f < TABLE_DEPTH; f++) used_slots[f] = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic in_word_t fam_word(input flags_t f, input logic [7:0] s, input logic p);
    in_word_t w;
    w = '0;
    w.operation = OP_LOAD;
    w.family_flags = f;
    w.family_slots = s;
    w.family_present = p;
    return w;
  endfunction

  function automatic in_word_t req_word(input flags_t rq, input flags_t pf, input flags_t ex,
                                        input logic [1:0] pm, input logic [1:0] av);
    in_word_t w;
    w = '0;
    w.operation = OP_APPEND;
    w.require_mask = rq;
    w.prefer_mask = pf;
    w.exclude_mask = ex;
    w.present_mode = pm;
    w.availability = av;
    return w;
  endfunction

  function automatic in_word_t ctl_word(input logic [1:0] op);
    in_word_t w;
    w = '0;
    w.operation = op;
    return w;
  endfunction

  function automatic out_word_t loc_word(input logic [3:0] rn, input logic as,
                                         input logic [3:0] fam, input logic [7:0] slot,
                                         input logic failed, input logic last);
    return {rn, as, fam, slot, failed, last};
  endfunction

  function automatic flags_t sparse_flags();
    return flags_t'($urandom_range(255) & $urandom_range(255) & $urandom_range(255));
  endfunction

  function automatic in_word_t random_word(input logic [1:0] op);
    in_word_t w;
    w.operation = op;
    w.family_flags = 8'($urandom_range(255));
    w.family_slots = 8'($urandom_range(255));
    w.family_present = 1'($urandom_range(1));
    w.require_mask = 8'($urandom_range(255));
    w.prefer_mask = 8'($urandom_range(255));
    w.exclude_mask = 8'($urandom_range(255));
    w.present_mode = 2'($urandom_range(3));
    w.availability = 2'($urandom_range(3));
    return w;
  endfunction

  task automatic add_row(input in_word_t w, input bit typed, input out_word_t loc);
    plan_word.push_back(w);
    plan_typed.push_back(typed);
    plan_loc.push_back(loc);
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t loc);
    if ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!item_ready);
    predict_word(w);
    if (typed) awaited_locations.push_back(loc);
    else foreach (solve_locs[k]) awaited_locations.push_back(solve_locs[k]);
    if (w.operation != OP_NONE) words_sent++;
  endtask

  task automatic send_random(input in_word_t w);
    if (words_sent < TOTAL_WORDS / 3) begin
      tx_idle_pct = 8;
      rx_idle_pct = 83;
    end else if (words_sent < 2 * TOTAL_WORDS / 3) begin
      tx_idle_pct = 83;
      rx_idle_pct = 8;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    send_word(w, 1'b0, '0);
  endtask

  task automatic hold_until_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (awaited_locations.size() != 0);
  endtask

  task automatic report(input string what, input out_word_t want, input out_word_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $write("%s: want req=%0d asg=%0d fam=%0d slot=%0d fail=%0d last=%0d, ",
             what, want.request_number, want.assigned, want.family_number,
             want.slot_number, want.failed, want.last);
      $display("got req=%0d asg=%0d fam=%0d slot=%0d fail=%0d last=%0d",
               got.request_number, got.assigned, got.family_number,
               got.slot_number, got.failed, got.last);
    end
  endtask

  always @(posedge clk) begin
    result_ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (awaited_locations.size() == 0) begin
        report("unexpected location", '0, result);
      end else begin
        head_loc = awaited_locations.pop_front();
        locations_checked++;
        if (result.request_number !== head_loc.request_number ||
            result.assigned !== head_loc.assigned ||
            result.family_number !== head_loc.family_number ||
            result.slot_number !== head_loc.slot_number ||
            result.failed !== head_loc.failed ||
            result.last !== head_loc.last)
          report("location mismatch", head_loc, result);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    int       nf;
    int       nr;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    tx_idle_pct = 8;
    rx_idle_pct = 83;
    fam_count = 0;
    req_count = 0;
    words_sent = 0;
    solves_seen = 0;
    aborts_seen = 0;
    locations_checked = 0;
    mismatch_count = 0;
    cycle_count = 0;
    for (int f = 0; f < TABLE_DEPTH; f++) used_slots[f] = '0;

    w = '1;
    w.operation = OP_NONE;
    add_row(ctl_word(OP_SOLVE), 1'b0, '0);
    add_row(w, 1'b0, '0);
    add_row(req_word(8'h01, 8'h00, 8'h00, PM_IGNORE, AV_REQUIRED), 1'b0, '0);
    add_row(ctl_word(OP_SOLVE), 1'b1, loc_word(4'd0, 1'b0, 4'd0, 8'd0, 1'b1, 1'b1));
    add_row(fam_word(8'hFF, 8'hFF, 1'b1), 1'b0, '0);
    add_row(req_word(8'hFF, 8'hFF, 8'h00, PM_REQUIRED, AV_REQUIRED), 1'b0, '0);
    add_row(ctl_word(OP_SOLVE), 1'b1, loc_word(4'd0, 1'b1, 4'd0, 8'd0, 1'b0, 1'b1));
    add_row(fam_word(8'h00, 8'h00, 1'b0), 1'b0, '0);
    add_row(fam_word(8'h0F, 8'h01, 1'b0), 1'b0, '0);
    add_row(fam_word(8'hF0, 8'h02, 1'b1), 1'b0, '0);
    add_row(req_word(8'h01, 8'hFF, 8'h80, PM_OPTIONAL, AV_OPTIONAL), 1'b0, '0);
    add_row(req_word(8'h01, 8'h02, 8'h00, PM_IGNORE, AV_REQUIRED), 1'b0, '0);
    add_row(req_word(8'h00, 8'h00, 8'h00, PM_RESERVED, AV_NEVER), 1'b0, '0);
    add_row(req_word(8'h00, 8'h10, 8'h00, PM_OPTIONAL, AV_RESERVED), 1'b0, '0);
    add_row(req_word(8'h00, 8'h00, 8'hFF, PM_IGNORE, AV_OPTIONAL), 1'b0, '0);
    add_row(ctl_word(OP_SOLVE), 1'b0, '0);
    add_row(fam_word(8'h01, 8'h03, 1'b0), 1'b0, '0);
    add_row(req_word(8'h00, 8'h00, 8'h00, PM_REQUIRED, AV_REQUIRED), 1'b0, '0);
    add_row(req_word(8'h00, 8'h00, 8'h00, PM_IGNORE, AV_REQUIRED), 1'b0, '0);
    add_row(ctl_word(OP_SOLVE), 1'b1, loc_word(4'd0, 1'b0, 4'd0, 8'd0, 1'b1, 1'b1));
    add_row(fam_word(8'h80, 8'h01, 1'b1), 1'b0, '0);
    add_row(req_word(8'h00, 8'h00, 8'h80, PM_IGNORE, AV_OPTIONAL), 1'b0, '0);
    add_row(ctl_word(OP_SOLVE), 1'b1, loc_word(4'd0, 1'b0, 4'd0, 8'd0, 1'b0, 1'b1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_word[i]) send_word(plan_word[i], plan_typed[i], plan_loc[i]);
    hold_until_drained();

    while (words_sent < TOTAL_WORDS) begin
      nf = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 4);
      nr = ($urandom_range(9) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 5);
      while (nf > 0 || nr > 0) begin
        if ($urandom_range(19) == 0) begin
          send_random(random_word($urandom_range(1) ? OP_NONE : OP_SOLVE));
        end else if (nr == 0 || (nf > 0 && $urandom_range(1))) begin
          w = random_word(OP_LOAD);
          case ($urandom_range(7))
            0: w.family_slots = 8'd0;
            1: w.family_slots = 8'($urandom_range(128, 255));
            default: w.family_slots = 8'($urandom_range(1, 3));
          endcase
          send_random(w);
          nf--;
        end else begin
          w = random_word(OP_APPEND);
          w.require_mask = $urandom_range(1) ? flags_t'('0) : sparse_flags();
          w.exclude_mask = sparse_flags();
          case ($urandom_range(9))
            0, 1, 2, 3, 4: w.availability = AV_REQUIRED;
            5, 6, 7:       w.availability = AV_OPTIONAL;
            8:             w.availability = AV_NEVER;
            default:       w.availability = AV_RESERVED;
          endcase
          send_random(w);
          nr--;
        end
      end
      send_random(random_word(OP_SOLVE));
      if ($urandom_range(5) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words through %0d solves (%0d aborted); %0d locations checked.",
             words_sent, solves_seen, aborts_seen, locations_checked);
    $display("Mismatching or unexpected locations: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
